/* rtl/arc_pkg.sv */
package arc_pkg;

  // Sequencer state codes, as reported on seq_state
  localparam logic [3:0] ST_INIT    = 4'd0;
  localparam logic [3:0] ST_STOP    = 4'd1;
  localparam logic [3:0] ST_WAIT    = 4'd2;
  localparam logic [3:0] ST_RST_PRE = 4'd3;
  localparam logic [3:0] ST_PUL_PRE = 4'd4;
  localparam logic [3:0] ST_WAIT1   = 4'd5;
  localparam logic [3:0] ST_RST1    = 4'd6;
  localparam logic [3:0] ST_PUL1    = 4'd7;
  localparam logic [3:0] ST_WAIT2   = 4'd8;
  localparam logic [3:0] ST_RST2    = 4'd9;
  localparam logic [3:0] ST_PUL2    = 4'd10;
  localparam logic [3:0] ST_WAIT3   = 4'd11;
  localparam logic [3:0] ST_RST3    = 4'd12;
  localparam logic [3:0] ST_PUL3    = 4'd13;
  localparam logic [3:0] ST_FAIL    = 4'd14;

  // Configuration register indexes
  localparam logic [2:0] CFG_ENABLE     = 3'd0;
  localparam logic [2:0] CFG_HOLD_TIME  = 3'd1;
  localparam logic [2:0] CFG_PRE_TIME   = 3'd2;
  localparam logic [2:0] CFG_WAIT_1     = 3'd3;
  localparam logic [2:0] CFG_WAIT_2     = 3'd4;
  localparam logic [2:0] CFG_WAIT_3     = 3'd5;
  localparam logic [2:0] CFG_MASK_0     = 3'd6;
  localparam logic [2:0] CFG_MASK_1     = 3'd7;

  // Tick counter fixed points
  localparam logic [15:0] TICK_MAX        = 16'hFFFF;
  localparam logic [15:0] TICK_PULSE_END  = 16'd2;
  localparam logic [15:0] TICK_TRIP_CHECK = 16'd4;
  localparam logic [15:0] TICK_SETTLE     = 16'd2;

  typedef struct packed {
    logic        enable;
    logic [14:0] hold_time;
    logic [14:0] pre_time;
    logic [14:0] wait_time_1;
    logic [14:0] wait_time_2;
    logic [14:0] wait_time_3;
    logic [15:0] reclose_mask_0;
    logic [15:0] reclose_mask_1;
  } arc_cfg_t;

  typedef struct packed {
    logic [3:0]  cur_state;
    logic [3:0]  prev_state;
    logic [15:0] tick_count;
    logic        pulse;
    logic        prot_clear;
    logic        acting;
  } arc_state_t;

  typedef struct packed {
    logic [15:0] prot_word_0;
    logic [15:0] prot_word_1;
    logic        trip_active;
    logic        breaker_off_trip;
    logic        stop_command;
    logic        ctrl_running;
  } arc_item_t;

endpackage

/* rtl/arc_step.sv */
module arc_step
  import arc_pkg::*;
(
  input  arc_cfg_t   cfg,
  input  arc_item_t  item,
  input  arc_state_t st,
  output arc_state_t st_nxt
);

  logic        allow;
  logic        entry;
  logic [15:0] tick_base;
  logic [15:0] tick_inc;
  logic [15:0] wait_limit;

  // Reclose permission from the protection words and blocking masks
  assign allow = ((item.prot_word_0 != '0) || (item.prot_word_1 != '0)) &&
                 ((item.prot_word_0 & cfg.reclose_mask_0) == '0) &&
                 ((item.prot_word_1 & cfg.reclose_mask_1) == '0);

  assign entry     = st.cur_state != st.prev_state;
  assign tick_base = entry ? '0 : st.tick_count;
  // Saturating increment of the tick counter
  assign tick_inc  = (tick_base == TICK_MAX) ? tick_base : tick_base + 16'd1;

  // Dead time of the current attempt
  always_comb begin
    case (st.cur_state)
      ST_WAIT1: wait_limit = {1'b0, cfg.wait_time_1};
      ST_WAIT2: wait_limit = {1'b0, cfg.wait_time_2};
      default:  wait_limit = {1'b0, cfg.wait_time_3};
    endcase
  end

  // One tick of the sequencer
  always_comb begin
    st_nxt = st;
    if (!cfg.enable) begin
      st_nxt.pulse      = 1'b0;
      st_nxt.prot_clear = 1'b0;
      st_nxt.acting     = 1'b0;
      st_nxt.cur_state  = ST_INIT;
    end else if (item.breaker_off_trip || item.stop_command) begin
      st_nxt.pulse      = 1'b0;
      st_nxt.prot_clear = 1'b0;
      st_nxt.cur_state  = ST_STOP;
    end else begin
      st_nxt.prev_state = st.cur_state;
      case (st.cur_state)
        ST_INIT: begin
          st_nxt.tick_count = tick_base;
          st_nxt.cur_state  = ST_STOP;
        end
        ST_STOP: begin
          st_nxt.tick_count = tick_base;
          if (item.ctrl_running) st_nxt.cur_state = ST_WAIT;
        end
        ST_WAIT: begin
          st_nxt.acting     = 1'b0;
          st_nxt.tick_count = tick_base;
          if (!item.ctrl_running) begin
            st_nxt.tick_count = tick_inc;
            if (tick_inc > TICK_SETTLE) begin
              if (!allow) begin
                st_nxt.cur_state = ST_STOP;
              end else if (cfg.pre_time == '0) begin
                st_nxt.cur_state = ST_WAIT1;
              end else if (tick_inc > {1'b0, cfg.pre_time}) begin
                st_nxt.cur_state = ST_RST_PRE;
              end
            end
          end
        end
        ST_RST_PRE, ST_RST1, ST_RST2, ST_RST3: begin
          st_nxt.tick_count = tick_inc;
          if (entry) st_nxt.prot_clear = 1'b1;
          if (tick_inc == TICK_PULSE_END) st_nxt.prot_clear = 1'b0;
          if (tick_inc == TICK_TRIP_CHECK) begin
            if (!item.trip_active) begin
              st_nxt.cur_state = st.cur_state + 4'd1;
            end else if (st.cur_state == ST_RST3) begin
              st_nxt.cur_state = ST_FAIL;
            end else begin
              st_nxt.cur_state = st.cur_state + 4'd2;
            end
          end
        end
        ST_PUL_PRE, ST_PUL1, ST_PUL2, ST_PUL3: begin
          st_nxt.tick_count = tick_inc;
          if (entry) begin
            st_nxt.pulse  = 1'b1;
            st_nxt.acting = st.cur_state != ST_PUL_PRE;
          end
          if (tick_inc == TICK_PULSE_END) st_nxt.pulse = 1'b0;
          if (tick_inc > {1'b0, cfg.hold_time}) st_nxt.cur_state = ST_WAIT;
          // Last attempt falls to fail on trip; earlier ones move on when allowed
          if (st.cur_state == ST_PUL3) begin
            if (item.trip_active) st_nxt.cur_state = ST_FAIL;
          end else if (allow) begin
            st_nxt.cur_state = st.cur_state + 4'd1;
          end
        end
        ST_WAIT1, ST_WAIT2, ST_WAIT3: begin
          st_nxt.tick_count = tick_inc;
          if (tick_inc > wait_limit) st_nxt.cur_state = allow ? st.cur_state + 4'd1 : ST_FAIL;
        end
        ST_FAIL: begin
          st_nxt.pulse      = 1'b0;
          st_nxt.prot_clear = 1'b0;
          if (!item.trip_active) begin
            st_nxt.cur_state = ST_STOP;
            st_nxt.acting    = 1'b0;
          end
        end
        default: begin
          st_nxt.cur_state = st.cur_state;
        end
      endcase
    end
  end

endmodule

/* rtl/auto_reclose_sequencer.sv */
// Latency: a result appears in the cycle after its input transfer (one register).
// Throughput: one tick item per cycle; the sequencer state update is a single
//   combinational pass, so the state registers close the only loop.
// A stalled result blocks a new input only while the output register is full.
// Reset (synchronous, rst_n low) clears the sequencer state, the output valid
//   and loads the configuration registers with their default values.
module auto_reclose_sequencer
  import arc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] prot_word_0, [31:16] prot_word_1, [32] trip_active,
  // [33] breaker_off_trip, [34] stop_command, [35] ctrl_running, [39:36] zero
  input  logic [39:0] in_tdata,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] pulse_enable, [1] protection reset pulse, [2] reclose_acting,
  // [6:3] seq_state, [7] zero
  output logic [7:0]  out_tdata,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  arc_cfg_t   cfg_r;
  arc_state_t st_r;
  arc_state_t st_nxt;
  arc_item_t  item;
  logic       in_fire;
  logic       out_tvalid_r;
  logic [6:0] out_data_r;

  assign item = '{
    prot_word_0:      in_tdata[15:0],
    prot_word_1:      in_tdata[31:16],
    trip_active:      in_tdata[32],
    breaker_off_trip: in_tdata[33],
    stop_command:     in_tdata[34],
    ctrl_running:     in_tdata[35]
  };

  // Accept when the output register is empty or drains this cycle
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  arc_step u_step (
    .cfg    (cfg_r),
    .item   (item),
    .st     (st_r),
    .st_nxt (st_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= 1'b0;
      cfg_r.hold_time      <= 15'd2000;
      cfg_r.pre_time       <= 15'd20;
      cfg_r.wait_time_1    <= 15'd400;
      cfg_r.wait_time_2    <= 15'd4000;
      cfg_r.wait_time_3    <= 15'd9000;
      cfg_r.reclose_mask_0 <= '0;
      cfg_r.reclose_mask_1 <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENABLE:     cfg_r.enable         <= cfg_wdata[0];
        CFG_HOLD_TIME:  cfg_r.hold_time      <= cfg_wdata[14:0];
        CFG_PRE_TIME:   cfg_r.pre_time       <= cfg_wdata[14:0];
        CFG_WAIT_1:     cfg_r.wait_time_1    <= cfg_wdata[14:0];
        CFG_WAIT_2:     cfg_r.wait_time_2    <= cfg_wdata[14:0];
        CFG_WAIT_3:     cfg_r.wait_time_3    <= cfg_wdata[14:0];
        CFG_MASK_0:     cfg_r.reclose_mask_0 <= cfg_wdata;
        CFG_MASK_1:     cfg_r.reclose_mask_1 <= cfg_wdata;
        default:        cfg_r.enable         <= cfg_r.enable;
      endcase
    end
  end

  // Advance the sequencer on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{cur_state: ST_INIT, prev_state: ST_INIT, tick_count: '0,
                pulse: 1'b0, prot_clear: 1'b0, acting: 1'b0};
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {st_nxt.cur_state, st_nxt.acting, st_nxt.prot_clear, st_nxt.pulse};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_data_r};

  // Full output register with a stalled consumer must block new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while result stalled");

  // Reported state tracks the sequencer state register
  a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_data_r[6:3] == st_r.cur_state))
    else $error("seq_state differs from sequencer state");

  // Disabled function clears outputs and forces init
  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_r.enable) |=> (out_data_r == {ST_INIT, 3'b000}))
    else $error("disabled tick did not clear outputs");

  // Forced stop lands in stop with pulse requests dropped
  a_forced_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cfg_r.enable && (item.breaker_off_trip || item.stop_command))
    |=> (st_r.cur_state == ST_STOP && !st_r.pulse && !st_r.prot_clear))
    else $error("forced stop not taken");

  // Unused state code is never reached
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cur_state <= ST_FAIL)
    else $error("sequencer state out of range");

endmodule

/* dv/arc_tick_checker.sv */
module arc_tick_checker
  import arc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  // Shadow of the configuration registers and of the sequencer state
  arc_cfg_t   shadow_cfg;
  logic [3:0] cur_st;
  logic [3:0] prev_st;
  logic [15:0] ticks;
  logic       pulse_q;
  logic       reset_q;
  logic       acting_q;

  // Predicted result words, oldest first
  logic [7:0] expected_ticks[$];

  function automatic void bump_ticks();
    if (ticks != TICK_MAX) ticks = ticks + 16'd1;
  endfunction

  // Advance the sequencer by one tick and return the packed result word
  function automatic logic [7:0] advance_sequencer(arc_item_t it);
    logic       allow;
    logic       entry;
    logic [3:0] s;
    logic [15:0] limit;
    allow = ((it.prot_word_0 != 16'd0) || (it.prot_word_1 != 16'd0)) &&
            ((it.prot_word_0 & shadow_cfg.reclose_mask_0) == 16'd0) &&
            ((it.prot_word_1 & shadow_cfg.reclose_mask_1) == 16'd0);
    if (!shadow_cfg.enable) begin
      pulse_q  = 1'b0;
      reset_q  = 1'b0;
      acting_q = 1'b0;
      cur_st   = ST_INIT;
    end else if (it.breaker_off_trip || it.stop_command) begin
      // forced stop keeps acting and leaves prev_st alone
      pulse_q = 1'b0;
      reset_q = 1'b0;
      cur_st  = ST_STOP;
    end else begin
      entry   = (cur_st != prev_st);
      s       = cur_st;
      prev_st = cur_st;
      case (s)
        ST_INIT: begin
          if (entry) ticks = 16'd0;
          cur_st = ST_STOP;
        end
        ST_STOP: begin
          if (entry) ticks = 16'd0;
          if (it.ctrl_running) cur_st = ST_WAIT;
        end
        ST_WAIT: begin
          if (entry) ticks = 16'd0;
          acting_q = 1'b0;
          if (!it.ctrl_running) begin
            bump_ticks();
            if (ticks > TICK_SETTLE) begin
              if (allow) begin
                if (shadow_cfg.pre_time == 15'd0) cur_st = ST_WAIT1;
                else if (ticks > {1'b0, shadow_cfg.pre_time}) cur_st = ST_RST_PRE;
              end else begin
                cur_st = ST_STOP;
              end
            end
          end
        end
        ST_RST_PRE, ST_RST1, ST_RST2, ST_RST3: begin
          if (entry) begin
            ticks   = 16'd0;
            reset_q = 1'b1;
          end
          bump_ticks();
          if (ticks == TICK_PULSE_END) reset_q = 1'b0;
          if (ticks == TICK_TRIP_CHECK) begin
            if (!it.trip_active) cur_st = s + 4'd1;
            else cur_st = (s == ST_RST3) ? ST_FAIL : s + 4'd2;
          end
        end
        ST_PUL_PRE, ST_PUL1, ST_PUL2, ST_PUL3: begin
          if (entry) begin
            ticks    = 16'd0;
            pulse_q  = 1'b1;
            acting_q = (s != ST_PUL_PRE);
          end
          bump_ticks();
          if (ticks == TICK_PULSE_END) pulse_q = 1'b0;
          if (ticks > {1'b0, shadow_cfg.hold_time}) cur_st = ST_WAIT;
          if (s == ST_PUL3) begin
            if (it.trip_active) cur_st = ST_FAIL;
          end else if (allow) begin
            cur_st = s + 4'd1;
          end
        end
        ST_WAIT1, ST_WAIT2, ST_WAIT3: begin
          limit = (s == ST_WAIT1) ? {1'b0, shadow_cfg.wait_time_1} :
                  (s == ST_WAIT2) ? {1'b0, shadow_cfg.wait_time_2} :
                                    {1'b0, shadow_cfg.wait_time_3};
          if (entry) ticks = 16'd0;
          bump_ticks();
          if (ticks > limit) cur_st = allow ? s + 4'd1 : ST_FAIL;
        end
        ST_FAIL: begin
          pulse_q = 1'b0;
          reset_q = 1'b0;
          if (!it.trip_active) begin
            cur_st   = ST_STOP;
            acting_q = 1'b0;
          end
        end
        default: ;
      endcase
    end
    return {1'b0, cur_st, acting_q, reset_q, pulse_q};
  endfunction

  function automatic int check_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : track
    int         errs;
    logic [7:0] want;
    arc_item_t  it;
    errs = 0;
    if (!rst_n) begin
      shadow_cfg.enable         = 1'b0;
      shadow_cfg.hold_time      = 15'd2000;
      shadow_cfg.pre_time       = 15'd20;
      shadow_cfg.wait_time_1    = 15'd400;
      shadow_cfg.wait_time_2    = 15'd4000;
      shadow_cfg.wait_time_3    = 15'd9000;
      shadow_cfg.reclose_mask_0 = 16'd0;
      shadow_cfg.reclose_mask_1 = 16'd0;
      cur_st   = ST_INIT;
      prev_st  = ST_INIT;
      ticks    = 16'd0;
      pulse_q  = 1'b0;
      reset_q  = 1'b0;
      acting_q = 1'b0;
      expected_ticks.delete();
    end else begin
      // compare a result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %02h", $time, out_tdata);
          errs++;
        end else begin
          want = expected_ticks.pop_front();
          errs += check_field("pulse_enable", {3'd0, want[0]}, {3'd0, out_tdata[0]});
          errs += check_field("prot_reset_pulse", {3'd0, want[1]}, {3'd0, out_tdata[1]});
          errs += check_field("reclose_acting", {3'd0, want[2]}, {3'd0, out_tdata[2]});
          errs += check_field("seq_state", want[6:3], out_tdata[6:3]);
        end
      end
      // predict the result of an input transfer with the settings before this edge
      if (in_tvalid && in_tready) begin
        it.prot_word_0      = in_tdata[15:0];
        it.prot_word_1      = in_tdata[31:16];
        it.trip_active      = in_tdata[32];
        it.breaker_off_trip = in_tdata[33];
        it.stop_command     = in_tdata[34];
        it.ctrl_running     = in_tdata[35];
        expected_ticks.push_back(advance_sequencer(it));
      end
      // track register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ENABLE:     shadow_cfg.enable         = cfg_wdata[0];
          CFG_HOLD_TIME:  shadow_cfg.hold_time      = cfg_wdata[14:0];
          CFG_PRE_TIME:   shadow_cfg.pre_time       = cfg_wdata[14:0];
          CFG_WAIT_1:     shadow_cfg.wait_time_1    = cfg_wdata[14:0];
          CFG_WAIT_2:     shadow_cfg.wait_time_2    = cfg_wdata[14:0];
          CFG_WAIT_3:     shadow_cfg.wait_time_3    = cfg_wdata[14:0];
          CFG_MASK_0:     shadow_cfg.reclose_mask_0 = cfg_wdata;
          CFG_MASK_1:     shadow_cfg.reclose_mask_1 = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count <= fail_count + errs;
    pending    <= expected_ticks.size();
  end

endmodule

/* dv/testbench.sv */
module testbench
  import arc_pkg::*;
();

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  int fail_count;
  int pending;

  // Traffic shaping, set per phase
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Settings currently loaded, used to shape the protection words
  arc_cfg_t cur_set;

  // Fault episode shaping
  int ep_left = 0;
  int ep_run = 0;
  int ep_trip_pct = 0;
  int ep_allow_pct = 0;

  auto_reclose_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  arc_tick_checker u_tick_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // Result side: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      out_tready    <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      holds_granted <= holds_granted + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [39:0] make_tick(logic [15:0] w0, logic [15:0] w1, logic trip,
                                            logic off, logic stp, logic run);
    return {4'd0, run, stp, off, trip, w1, w0};
  endfunction

  // Fault episodes: a short running stretch, then the converter stopped, with trip
  // and allow rates drawn per episode and fresh words per tick, plus rare stop noise
  function automatic logic [39:0] next_fault_tick();
    logic [15:0] w0;
    logic [15:0] w1;
    logic        run;
    if (ep_left == 0) begin
      ep_left = $urandom_range(60, 6);
      ep_run  = $urandom_range(3, 1);
      case ($urandom_range(3))
        0: ep_trip_pct = 0;
        1: ep_trip_pct = 25;
        2: ep_trip_pct = 75;
        default: ep_trip_pct = 100;
      endcase
      ep_allow_pct = ($urandom_range(3) == 0) ? 60 : 97;
    end
    ep_left--;
    run = (ep_run > 0) ? 1'b1 : ($urandom_range(99) < 2);
    if (ep_run > 0) ep_run--;
    w0 = 16'($urandom);
    w1 = 16'($urandom);
    if ($urandom_range(99) < ep_allow_pct) begin
      w0 = w0 & ~cur_set.reclose_mask_0;
      w1 = w1 & ~cur_set.reclose_mask_1;
    end
    if ($urandom_range(99) < 4) begin
      w0 = 16'd0;
      w1 = 16'd0;
    end
    return make_tick(w0, w1, $urandom_range(99) < ep_trip_pct, $urandom_range(99) < 1,
                     $urandom_range(99) < 1, run);
  endfunction

  // Offer one tick, with random gaps, and hold it until the transfer
  task automatic push_tick(logic [39:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure(logic en, logic [14:0] rdy, logic [14:0] pre, logic [14:0] w1,
                           logic [14:0] w2, logic [14:0] w3, logic [15:0] m0,
                           logic [15:0] m1);
    logic [15:0] vals[8];
    drain();
    cur_set.enable         = en;
    cur_set.hold_time      = rdy;
    cur_set.pre_time       = pre;
    cur_set.wait_time_1    = w1;
    cur_set.wait_time_2    = w2;
    cur_set.wait_time_3    = w3;
    cur_set.reclose_mask_0 = m0;
    cur_set.reclose_mask_1 = m1;
    vals[CFG_ENABLE]     = {15'd0, en};
    vals[CFG_HOLD_TIME]  = {1'b0, rdy};
    vals[CFG_PRE_TIME]   = {1'b0, pre};
    vals[CFG_WAIT_1]     = {1'b0, w1};
    vals[CFG_WAIT_2]     = {1'b0, w2};
    vals[CFG_WAIT_3]     = {1'b0, w3};
    vals[CFG_MASK_0]     = m0;
    vals[CFG_MASK_1]     = m1;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= i[2:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int n, bit press);
    for (int i = 0; i < n; i++) begin
      if (press && i == 40) holds_asked <= holds_asked + 1;
      push_tick(next_fault_tick());
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    cur_set   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled after reset: outputs cleared, state held at init
    push_tick(make_tick(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1));
    push_tick(make_tick(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));

    // Walk one full sequence: forced stops, pre-attempt success, attempt 1 with
    // trip held, blocked words in the second dead time into fail, then recovery
    configure(1'b1, 15'd3, 15'd3, 15'd2, 15'd1, 15'd0, 16'h8000, 16'h0001);
    push_tick(make_tick(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));
    push_tick(make_tick(16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0));
    push_tick(make_tick(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    push_tick(make_tick(16'h0001, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
    repeat (5) push_tick(make_tick(16'h0001, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
    repeat (3) push_tick(make_tick(16'h0000, 16'h0002, 1'b0, 1'b0, 1'b0, 1'b0));
    repeat (4) push_tick(make_tick(16'h7FFE, 16'hFFFE, 1'b0, 1'b0, 1'b0, 1'b0));
    repeat (4) push_tick(make_tick(16'h0100, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0));
    repeat (2) push_tick(make_tick(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0));
    push_tick(make_tick(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));

    // Zero times everywhere: pre-attempt skipped, zero ready time
    configure(1'b1, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 16'h0000, 16'h0000);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(150, 1'b0);

    configure(1'b1, 15'd5, 15'd2, 15'd3, 15'd4, 15'd5, 16'h00F0, 16'h0F00);
    send_idle_pct = 55;
    run_random(150, 1'b0);

    configure(1'b0, 15'd7, 15'd9, 15'd1, 15'd1, 15'd1, 16'hFFFF, 16'hFFFF);
    send_idle_pct = 0;
    stall_pct     = 55;
    run_random(40, 1'b0);

    // Receiver stalls with one long hold-off to back up the input
    configure(1'b1, 15'd2, 15'd1, 15'd1, 15'd2, 15'd3, 16'hFFFF, 16'h0000);
    run_random(150, 1'b1);

    configure(1'b1, 15'd8, 15'd6, 15'd6, 15'd2, 15'd9, 16'h0000, 16'hFFFF);
    send_idle_pct = 6;
    stall_pct     = 6;
    run_random(150, 1'b0);

    // Largest times: enter the first dead time and count against the top limit
    configure(1'b1, 15'h7FFF, 15'd0, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'h0F0F, 16'hF0F0);
    send_idle_pct = 0;
    stall_pct     = 0;
    push_tick(make_tick(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));
    push_tick(make_tick(16'h1000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
    repeat (60) push_tick(make_tick(16'h1000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));

    configure(1'b1, 15'd1, 15'd4, 15'd2, 15'd0, 15'd1, 16'h8001, 16'h0180);
    send_idle_pct = 6;
    stall_pct     = 6;
    run_random(120, 1'b0);

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* auto_reclose_sequencer.f */
rtl/arc_pkg.sv
rtl/arc_step.sv
rtl/auto_reclose_sequencer.sv
dv/arc_tick_checker.sv
dv/testbench.sv
